FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the running statistics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assert failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assert failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: src/rsw_pkg.sv
// ----------------------------------------------------------------------------
// rsw_pkg
// Opcodes and shared types of the running statistics block.
// ----------------------------------------------------------------------------
package rsw_pkg;
   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_MERGE = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam logic signed [31:0] MIN_INIT = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MAX_INIT = 32'sh8000_0000;
   localparam int DIV_W = 64;
   localparam int CNT_W = 7;
endpackage

FILE: src/rsw_divider.sv
// ----------------------------------------------------------------------------
// rsw_divider
// Radix-2 restoring divider, unsigned 64 by 64 bits, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rsw_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff;
   logic [rsw_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      trial   = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[64]) begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rsw_pkg::CNT_W'(rsw_pkg::DIV_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) dvs_ff <= divisor;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

FILE: src/running_stats_welford.sv
// Path to rsp_valid: when the count ends below two, the result loads from S_RESULT;
// else the variance division (S_DIV2, S_WAIT2) runs first, preceded, for an add or
// merge that changes a non-empty accumulator, by the Welford update (mean division
// plus products in two 32x32 passes). The next beat is accepted in the cycle after the
// result is loaded; the output register holds a stalled result while the core runs on.
// Synchronous active-high reset empties the accumulator (min INT32_MAX, max INT32_MIN).
// ----------------------------------------------------------------------------
// running_stats_welford
// Integer running statistics: count, sum, mean, min, max, sum of squared
// deviations and variance, updated by clear, add and merge beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module running_stats_welford (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_sample,
   input  logic [31:0]        req_other_count,
   input  logic signed [63:0] req_other_sum,
   input  logic [63:0]        req_other_sum_sq,
   input  logic signed [31:0] req_other_mean,
   input  logic signed [31:0] req_other_min,
   input  logic signed [31:0] req_other_max,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_total_count,
   output logic signed [63:0] rsp_total_sum,
   output logic signed [31:0] rsp_mean_out,
   output logic signed [31:0] rsp_min_out,
   output logic signed [31:0] rsp_max_out,
   output logic [63:0]        rsp_sum_sq_out,
   output logic [63:0]        rsp_variance_out,
   output logic               rsp_count_full
);
   typedef enum logic [3:0] {
      S_IDLE, S_MUL1A, S_MUL1, S_MUL2A, S_MUL2, S_DIV1, S_WAIT1, S_PRODA, S_PROD,
      S_UPD, S_DIV2, S_WAIT2, S_RESULT
   } state_type;

   state_type state_ff;
   logic [31:0] cnt_ff;
   logic [63:0] sum_ff, sq_ff, s_ff;
   logic signed [31:0] mean_ff, min_ff, max_ff;
   logic full_ff, merge_ff;
   // latched request
   logic signed [31:0] smp_ff;
   logic [31:0] ocnt_ff;
   logic [63:0] osum_ff, osq_ff;
   logic signed [31:0] omean_ff;
   // output register
   logic [31:0] out_cnt_ff;
   logic [63:0] out_sum_ff, out_sq_ff, var_ff;
   logic signed [31:0] out_mean_ff, out_min_ff, out_max_ff;
   logic out_full_ff;
   logic out_load;
   // shared multiplier: 64-bit operand times 33-bit signed operand
   logic [63:0] ma;
   logic signed [32:0] mb;
   logic        mul_hi;
   logic [31:0] mx;
   logic [63:0] mxy, plo_ff;
   logic [31:0] mid;
   logic [63:0] mprod;
   logic signed [31:0] nm;
   logic        div_start, div_busy;
   logic [63:0] div_num, div_den, div_q;
   logic        sum_neg;
   logic [63:0] sum_mag;
   logic        out_ff;
   logic [63:0] clamped;
   logic [32:0] cnt_sum;

   // Low half of the product in two passes: low word first, then high word
   // of ma times the low word of mb, minus the low word of ma for a negative mb.
   assign mul_hi = state_ff inside {S_MUL1, S_MUL2, S_PROD};
   assign mx     = mul_hi ? ma[63:32] : ma[31:0];
   assign mxy    = 64'(mx) * 64'(mb[31:0]);
   assign mid    = mxy[31:0] - (mb[32] ? ma[31:0] : 32'd0);
   assign mprod  = plo_ff + {mid, 32'd0};

   assign sum_neg = sum_ff[63];
   assign sum_mag = sum_neg ? (64'd0 - sum_ff) : sum_ff;
   assign nm = sum_neg ? 32'(64'd0 - div_q) : 32'(div_q);
   assign cnt_sum = {1'b0, cnt_ff} + {1'b0, req_other_count};

   always_comb begin
      ma = '0;
      mb = '0;
      case (state_ff)
         S_MUL1A, S_MUL1: begin ma = sum_ff;  mb = 33'(mean_ff); end
         S_MUL2A, S_MUL2: begin ma = osum_ff; mb = 33'(omean_ff); end
         S_PRODA, S_PROD: begin
            if (merge_ff) begin
               ma = sum_ff; mb = 33'(nm);
            end else begin
               ma = 64'(smp_ff) - 64'(mean_ff);
               mb = 33'(smp_ff) - 33'(nm);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num = sum_mag;
      div_den = 64'(cnt_ff);
      if (state_ff == S_DIV1) div_start = 1'b1;
      if (state_ff == S_DIV2) begin
         div_start = 1'b1;
         div_num = sq_ff;
         div_den = 64'(cnt_ff - 32'd1);
      end
   end

   always_comb begin
      if (s_ff[63] && ((64'd0 - s_ff) > sq_ff)) clamped = '0;
      else clamped = sq_ff + s_ff;
   end

   // load the output register once the previous result has left
   assign out_load = !out_ff &&
                     ((state_ff == S_WAIT2 && !div_busy) ||
                      (state_ff == S_RESULT && cnt_ff < 32'd2));

   rsw_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff   <= 1'b0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         mean_ff  <= '0;
         min_ff   <= rsw_pkg::MIN_INIT;
         max_ff   <= rsw_pkg::MAX_INIT;
         full_ff  <= 1'b0;
         merge_ff <= 1'b0;
      end else begin
         if (out_load) out_ff <= 1'b1;
         else if (out_ff && !rsp_stall) out_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  full_ff  <= 1'b0;
                  smp_ff   <= req_sample;
                  ocnt_ff  <= req_other_count;
                  osum_ff  <= req_other_sum;
                  osq_ff   <= req_other_sum_sq;
                  omean_ff <= req_other_mean;
                  state_ff <= S_RESULT;
                  case (rsw_pkg::opcode_type'(req_opcode))
                     rsw_pkg::OP_CLEAR: begin
                        cnt_ff  <= '0;
                        sum_ff  <= '0;
                        sq_ff   <= '0;
                        mean_ff <= '0;
                        min_ff  <= rsw_pkg::MIN_INIT;
                        max_ff  <= rsw_pkg::MAX_INIT;
                     end
                     rsw_pkg::OP_ADD: begin
                        if (cnt_ff == 32'hFFFF_FFFF) begin
                           full_ff <= 1'b1;
                        end else begin
                           if (req_sample > max_ff) max_ff <= req_sample;
                           if (req_sample < min_ff) min_ff <= req_sample;
                           sum_ff <= sum_ff + 64'(req_sample);
                           cnt_ff <= cnt_ff + 32'd1;
                           merge_ff <= 1'b0;
                           if (cnt_ff == '0) begin
                              sq_ff   <= '0;
                              mean_ff <= req_sample;
                           end else begin
                              state_ff <= S_DIV1;
                           end
                        end
                     end
                     rsw_pkg::OP_MERGE: begin
                        if (req_other_count == '0) begin
                           // nothing to merge
                        end else if (cnt_ff == '0) begin
                           cnt_ff  <= req_other_count;
                           sum_ff  <= req_other_sum;
                           sq_ff   <= req_other_sum_sq;
                           mean_ff <= req_other_mean;
                           min_ff  <= req_other_min;
                           max_ff  <= req_other_max;
                        end else if (cnt_sum[32]) begin
                           full_ff <= 1'b1;
                        end else begin
                           if (req_other_max > max_ff) max_ff <= req_other_max;
                           if (req_other_min < min_ff) min_ff <= req_other_min;
                           merge_ff <= 1'b1;
                           state_ff <= S_MUL1A;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_MUL1A: begin
               plo_ff   <= mxy;
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               s_ff <= sq_ff + mprod + osq_ff;
               state_ff <= S_MUL2A;
            end
            S_MUL2A: begin
               plo_ff   <= mxy;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               // sq_ff now carries the combined pre-clamp sum
               sq_ff    <= s_ff + mprod;
               cnt_ff   <= cnt_ff + ocnt_ff;
               sum_ff   <= sum_ff + osum_ff;
               state_ff <= S_DIV1;
            end
            S_DIV1: state_ff <= S_WAIT1;
            S_WAIT1: if (!div_busy) state_ff <= S_PRODA;
            S_PRODA: begin
               plo_ff   <= mxy;
               state_ff <= S_PROD;
            end
            S_PROD: begin
               mean_ff  <= nm;
               s_ff     <= merge_ff ? (64'd0 - mprod) : mprod;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               sq_ff    <= clamped;
               state_ff <= S_RESULT;
            end
            S_DIV2: state_ff <= S_WAIT2;
            S_WAIT2: if (out_load) state_ff <= S_IDLE;
            S_RESULT: begin
               if (cnt_ff >= 32'd2) state_ff <= S_DIV2;
               else if (out_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (out_load) begin
         out_cnt_ff  <= cnt_ff;
         out_sum_ff  <= sum_ff;
         out_mean_ff <= mean_ff;
         out_min_ff  <= min_ff;
         out_max_ff  <= max_ff;
         out_sq_ff   <= sq_ff;
         var_ff      <= (state_ff == S_WAIT2) ? div_q : 64'd0;
         out_full_ff <= full_ff;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = out_ff;
   assign rsp_total_count  = out_cnt_ff;
   assign rsp_total_sum    = out_sum_ff;
   assign rsp_mean_out     = out_mean_ff;
   assign rsp_min_out      = out_min_ff;
   assign rsp_max_out      = out_max_ff;
   assign rsp_sum_sq_out   = out_sq_ff;
   assign rsp_variance_out = var_ff;
   assign rsp_count_full   = out_full_ff;

   `ASSERT_IMPLIES(a_idle_ready, clock, reset, state_ff == S_IDLE, !req_stall)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, out_ff && rsp_stall, out_ff)
   `ASSERT_NEXT(a_div_busy, clock, reset, div_start, div_busy)
   `ASSERT_IMPLIES(a_full_add, clock, reset, out_ff && out_full_ff, out_cnt_ff != 32'd0)
endmodule
